FILE: src/tts_pkg.sv
// ----------------------------------------------------------------------------
// tts_pkg
// Shared widths, types and helpers for the triangle tile shader.
// ----------------------------------------------------------------------------
`default_nettype none

package tts_pkg;

  // Cell size in sub-pixels and palette size
  localparam int CELL_WIDTH_PX  = 2;
  localparam int CELL_HEIGHT_PX = 4;
  localparam int PALETTE_SIZE   = 6;

  localparam int FRAC_BITS = 16;
  localparam int COORD_W   = 10;
  localparam int INV_W     = 16;
  localparam int OUT_W     = 11;

  // Signed widths of the datapath, with margin for cell sizes up to 8
  localparam int DX_W  = COORD_W + 1;
  localparam int PX_W  = DX_W + 4;
  localparam int B_W   = PX_W + INV_W + 1;
  localparam int A_W   = B_W + 1;
  localparam int COL_W = A_W - FRAC_BITS;
  localparam int ROW_W = B_W - FRAC_BITS;
  localparam int SUM_W = COL_W + 3;

  // Multiple of the palette size that lifts any sum above zero
  localparam int SUM_BIAS = PALETTE_SIZE * (1 << (SUM_W - 4));

  localparam int OUT_MAX = (1 << (OUT_W - 1)) - 1;
  localparam int OUT_MIN = -(1 << (OUT_W - 1));

  typedef enum logic [1:0] {
    CFG_ORIGIN_COL = 2'd0,
    CFG_ORIGIN_ROW = 2'd1,
    CFG_INV_SIDE   = 2'd2,
    CFG_INV_HEIGHT = 2'd3
  } cfg_idx_e;

  // Skewed lattice coordinates in signed Q.16
  typedef struct packed {
    logic signed [A_W-1:0] a;
    logic signed [B_W-1:0] b;
  } lattice_t;

  typedef struct packed {
    logic [OUT_W-1:0] tri_col;
    logic [OUT_W-1:0] tri_row;
    logic             upward;
    logic [2:0]       color_index;
  } result_t;

  // Residue mod 3: base-4 digits all weigh 1 mod 3
  function automatic logic [1:0] mod3(input logic [SUM_W-1:0] v);
    logic [4:0] s1;
    logic [2:0] s2;
    logic [1:0] r;
    s1 = '0;
    for (int i = 0; i < SUM_W / 2; i++) begin
      s1 = s1 + 5'(v[2*i +: 2]);
    end
    s2 = 3'(s1[1:0]) + 3'(s1[3:2]) + 3'(s1[4]);
    if (s2 >= 3'd6) begin
      r = 2'(s2 - 3'd6);
    end else if (s2 >= 3'd3) begin
      r = 2'(s2 - 3'd3);
    end else begin
      r = s2[1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: src/triangle_tile_shader_top.sv
// ----------------------------------------------------------------------------
// triangle_tile_shader_top
// Maps a screen cell to its triangle lattice cell and palette entry.
//
// Input stream carries one screen cell per transaction (screen_x, screen_y);
// output stream returns one result per input in the same order: lattice
// column and row (saturated to 11 bits), the upward flag on tuser and the
// palette index 0..5. Registers loaded on the write port: origin column,
// origin row, 1/side and 1/height in Q0.16. The user loads them only while
// the block is idle; the block itself does not enforce this.
//
// Three register stages: input, lattice coordinates, result. Throughput is
// one item per clock while the receiver keeps tready high. The critical path
// is the offset subtract, one 15x17 multiply and the skew subtract in the
// lattice stage. Each stage moves whenever the stage after it is empty or
// moving, so a stalled receiver fills the pipe and then drops s_axis tready;
// bubbles are still absorbed while the output waits.
// Reset clears all valid bits and loads the default registers
// (origin 0/0, inv_side 4096, inv_height 4730).
// ----------------------------------------------------------------------------
`default_nettype none

module triangle_tile_shader_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_addr_i,
  input  wire logic [15:0] cfg_wdata_i,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [23:0] s_axis_tdata_i,   // screen_x[9:0], screen_y[19:10], zero pad
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [31:0]      m_axis_tdata_o,   // tri_col[10:0], tri_row[21:11],
                                             // color_index[24:22], zero pad
  output logic             m_axis_tuser_o    // upward
);

  logic [tts_pkg::COORD_W-1:0] origin_col_q, origin_row_q;
  logic [tts_pkg::INV_W-1:0]   inv_side_q, inv_height_q;

  logic                        s1_valid_q, s2_valid_q, out_valid_q;
  logic                        s1_ready, s2_ready, out_ready;
  logic [tts_pkg::COORD_W-1:0] x_q, y_q;
  tts_pkg::lattice_t           lattice_d, lattice_q;
  tts_pkg::result_t            res_d, res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      origin_col_q <= '0;
      origin_row_q <= '0;
      inv_side_q   <= 16'd4096;
      inv_height_q <= 16'd4730;
    end else if (cfg_we_i) begin
      unique case (tts_pkg::cfg_idx_e'(cfg_addr_i))
        tts_pkg::CFG_ORIGIN_COL: origin_col_q <= cfg_wdata_i[tts_pkg::COORD_W-1:0];
        tts_pkg::CFG_ORIGIN_ROW: origin_row_q <= cfg_wdata_i[tts_pkg::COORD_W-1:0];
        tts_pkg::CFG_INV_SIDE:   inv_side_q   <= cfg_wdata_i;
        tts_pkg::CFG_INV_HEIGHT: inv_height_q <= cfg_wdata_i;
      endcase
    end
  end

  assign out_ready = !out_valid_q || m_axis_tready_i;
  assign s2_ready  = !s2_valid_q || out_ready;
  assign s1_ready  = !s1_valid_q || s2_ready;

  tts_lattice u_lattice (
    .screen_x_i   (x_q),
    .screen_y_i   (y_q),
    .origin_col_i (origin_col_q),
    .origin_row_i (origin_row_q),
    .inv_side_i   (inv_side_q),
    .inv_height_i (inv_height_q),
    .lattice_o    (lattice_d)
  );

  tts_classify u_classify (
    .lattice_i (lattice_q),
    .result_o  (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_valid_q <= s_axis_tvalid_i;
      end
      if (s2_ready) begin
        s2_valid_q <= s1_valid_q;
      end
      if (out_ready) begin
        out_valid_q <= s2_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_ready && s_axis_tvalid_i) begin
      x_q <= s_axis_tdata_i[9:0];
      y_q <= s_axis_tdata_i[19:10];
    end
    if (s2_ready && s1_valid_q) begin
      lattice_q <= lattice_d;
    end
    if (out_ready && s2_valid_q) begin
      res_q <= res_d;
    end
  end

  assign s_axis_tready_o = s1_ready;
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {7'd0, res_q.color_index, res_q.tri_row, res_q.tri_col};
  assign m_axis_tuser_o  = res_q.upward;

  a_s1_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> s1_valid_q)
    else $error("accepted item did not enter the input stage");

  a_out_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_valid_q && out_ready |=> out_valid_q)
    else $error("lattice stage item lost on its way to the output");

  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && s2_valid_q && out_valid_q && !m_axis_tready_i |-> !s_axis_tready_o)
    else $error("input accepted while the pipeline is full and stalled");

  a_color_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> res_q.color_index <= 3'd5)
    else $error("palette index out of range");

endmodule

`default_nettype wire

FILE: src/tts_lattice.sv
// ----------------------------------------------------------------------------
// tts_lattice
// Origin offset, cell scaling and skew into lattice coordinates a and b.
// ----------------------------------------------------------------------------
`default_nettype none

module tts_lattice (
  input  wire logic [tts_pkg::COORD_W-1:0] screen_x_i,
  input  wire logic [tts_pkg::COORD_W-1:0] screen_y_i,
  input  wire logic [tts_pkg::COORD_W-1:0] origin_col_i,
  input  wire logic [tts_pkg::COORD_W-1:0] origin_row_i,
  input  wire logic [tts_pkg::INV_W-1:0]   inv_side_i,
  input  wire logic [tts_pkg::INV_W-1:0]   inv_height_i,
  output tts_pkg::lattice_t                lattice_o
);

  logic signed [tts_pkg::DX_W-1:0] dx, dy;
  logic signed [tts_pkg::PX_W-1:0] px, py;
  logic signed [tts_pkg::B_W-1:0]  b, pa;

  assign dx = $signed({1'b0, screen_x_i}) - $signed({1'b0, origin_col_i});
  assign dy = $signed({1'b0, screen_y_i}) - $signed({1'b0, origin_row_i});

  assign px = tts_pkg::PX_W'(dx) * $signed(tts_pkg::PX_W'(tts_pkg::CELL_WIDTH_PX));
  assign py = tts_pkg::PX_W'(dy) * $signed(tts_pkg::PX_W'(tts_pkg::CELL_HEIGHT_PX));

  assign b  = tts_pkg::B_W'(py) * tts_pkg::B_W'($signed({1'b0, inv_height_i}));
  assign pa = tts_pkg::B_W'(px) * tts_pkg::B_W'($signed({1'b0, inv_side_i}));

  // b >>> 1 is floor(b / 2)
  assign lattice_o.b = b;
  assign lattice_o.a = tts_pkg::A_W'(pa) - tts_pkg::A_W'(b >>> 1);

endmodule

`default_nettype wire

FILE: src/tts_classify.sv
// ----------------------------------------------------------------------------
// tts_classify
// Floors lattice coordinates, finds orientation and picks the palette entry.
// ----------------------------------------------------------------------------
`default_nettype none

module tts_classify (
  input  tts_pkg::lattice_t lattice_i,
  output tts_pkg::result_t  result_o
);

  logic signed [tts_pkg::COL_W-1:0] col;
  logic signed [tts_pkg::ROW_W-1:0] row;
  logic [tts_pkg::FRAC_BITS:0]      frac_sum;
  logic                             up;
  logic signed [tts_pkg::SUM_W-1:0] col_ext, row_ext, sum;
  logic [tts_pkg::SUM_W-1:0]        biased;
  logic [1:0]                       r3;

  function automatic logic [tts_pkg::OUT_W-1:0] sat_out(
    input logic signed [tts_pkg::COL_W-1:0] v
  );
    logic [tts_pkg::OUT_W-1:0] r;
    if (v > $signed(tts_pkg::COL_W'(tts_pkg::OUT_MAX))) begin
      r = tts_pkg::OUT_W'(tts_pkg::OUT_MAX);
    end else if (v < $signed(tts_pkg::COL_W'(tts_pkg::OUT_MIN))) begin
      r = tts_pkg::OUT_W'(tts_pkg::OUT_MIN);
    end else begin
      r = v[tts_pkg::OUT_W-1:0];
    end
    return r;
  endfunction

  assign col = lattice_i.a[tts_pkg::A_W-1:tts_pkg::FRAC_BITS];
  assign row = lattice_i.b[tts_pkg::B_W-1:tts_pkg::FRAC_BITS];

  assign frac_sum = {1'b0, lattice_i.a[tts_pkg::FRAC_BITS-1:0]}
                  + {1'b0, lattice_i.b[tts_pkg::FRAC_BITS-1:0]};
  assign up = frac_sum[tts_pkg::FRAC_BITS];

  assign col_ext = tts_pkg::SUM_W'(col);
  assign row_ext = tts_pkg::SUM_W'(row);
  assign sum     = col_ext + (row_ext <<< 1) + $signed({{(tts_pkg::SUM_W-1){1'b0}}, up});
  // bias is a multiple of 6, keeps the residue and makes the value positive
  assign biased  = sum + tts_pkg::SUM_W'(tts_pkg::SUM_BIAS);
  assign r3      = tts_pkg::mod3(biased);

  // combine mod 2 and mod 3 residues
  always_comb begin
    result_o.tri_col = sat_out(col);
    result_o.tri_row = sat_out(tts_pkg::COL_W'(row));
    result_o.upward  = up;
    if (r3[0] == biased[0]) begin
      result_o.color_index = {1'b0, r3};
    end else begin
      result_o.color_index = {1'b0, r3} + 3'd3;
    end
  end

endmodule

`default_nettype wire

FILE: test/triangle_tile_shader_top_tb.sv
// ----------------------------------------------------------------------------
// triangle_tile_shader_top_tb
// Self-checking bench for the triangle lattice cell lookup.
//
// Streams screen cells through the block under a series of register settings,
// from the reset values through saturating and zero-reciprocal extremes to
// random ones. A scoreboard predicts lattice column, row, upward flag and
// palette index for each accepted cell and checks every output transaction in
// order. The sender runs in bursts with gaps and the receiver stalls on its
// own patterns, including one long hold-off that backs up the pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module triangle_tile_shader_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tts_pkg::*;

  localparam int LATENCY     = 3;
  localparam int HOLD_CYCLES = 200;

  // Predicts the lattice lookup and keeps the results still owed by the block
  class cell_scoreboard;
    logic [9:0]  org_col;
    logic [9:0]  org_row;
    logic [15:0] inv_side;
    logic [15:0] inv_height;
    result_t     owed_q[$];
    int unsigned failures;

    function new();
      org_col    = '0;
      org_row    = '0;
      inv_side   = 16'd4096;
      inv_height = 16'd4730;
      failures   = 0;
    endfunction

    function void set_reg(cfg_idx_e idx, logic [15:0] val);
      case (idx)
        CFG_ORIGIN_COL: org_col = val[9:0];
        CFG_ORIGIN_ROW: org_row = val[9:0];
        CFG_INV_SIDE:   inv_side = val;
        CFG_INV_HEIGHT: inv_height = val;
        default: ;
      endcase
    endfunction

    function logic [10:0] clamp11(longint v);
      if (v > OUT_MAX) return 11'(OUT_MAX);
      if (v < OUT_MIN) return 11'(OUT_MIN);
      return v[10:0];
    endfunction

    function result_t lookup_cell(logic [9:0] x, logic [9:0] y);
      longint  dx, dy, a, b, col, row, fa, fb, k;
      logic    up;
      result_t r;
      dx  = longint'(x) - longint'(org_col);
      dy  = longint'(y) - longint'(org_row);
      b   = dy * CELL_HEIGHT_PX * longint'(inv_height);
      // arithmetic shift rounds b/2 toward minus infinity
      a   = dx * CELL_WIDTH_PX * longint'(inv_side) - (b >>> 1);
      col = a >>> FRAC_BITS;
      row = b >>> FRAC_BITS;
      fa  = a & 64'hFFFF;
      fb  = b & 64'hFFFF;
      up  = (fa + fb >= 64'd65536);
      k   = (col + 2 * row + (up ? 1 : 0)) % PALETTE_SIZE;
      if (k < 0) k += PALETTE_SIZE;
      r.tri_col     = clamp11(col);
      r.tri_row     = clamp11(row);
      r.upward      = up;
      r.color_index = k[2:0];
      return r;
    endfunction

    function void note_cell(logic [9:0] x, logic [9:0] y);
      owed_q.push_back(lookup_cell(x, y));
    endfunction

    function int pending();
      return owed_q.size();
    endfunction

    function void report(string msg);
      failures++;
      if (failures <= 10) $display("%t: %s", $realtime, msg);
    endfunction

    function void check_result(logic [31:0] data, logic user);
      result_t e;
      if (owed_q.size() == 0) begin
        report($sformatf("unexpected result tdata=%h tuser=%b", data, user));
        return;
      end
      e = owed_q.pop_front();
      if (data[10:0] !== e.tri_col)
        report($sformatf("tri_col expected %0d actual %0d",
                         $signed(e.tri_col), $signed(data[10:0])));
      if (data[21:11] !== e.tri_row)
        report($sformatf("tri_row expected %0d actual %0d",
                         $signed(e.tri_row), $signed(data[21:11])));
      if (data[24:22] !== e.color_index)
        report($sformatf("color_index expected %0d actual %0d",
                         e.color_index, data[24:22]));
      if (user !== e.upward)
        report($sformatf("upward expected %b actual %b", e.upward, user));
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we;
  logic [1:0]  cfg_addr;
  logic [15:0] cfg_wdata;
  logic        s_tvalid;
  logic        s_tready;
  logic [23:0] s_tdata;
  logic        m_tvalid;
  logic        m_tready;
  logic [31:0] m_tdata;
  logic        m_tuser;
  logic        hold_req;

  cell_scoreboard sb;

  triangle_tile_shader_top uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we),
    .cfg_addr_i      (cfg_addr),
    .cfg_wdata_i     (cfg_wdata),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #3_000_000;
    $display("Test completed with failures");
    $finish;
  end

  // output transactions
  always @(posedge clk_i) begin
    if (rst_ni && m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser);
  end

  // receiver: stall patterns in segments, plus a long hold-off on request
  initial begin : rx_side
    int mode;
    int seg;
    int phase;
    m_tready <= 1'b0;
    phase = 0;
    forever begin
      mode = $urandom_range(0, 3);
      seg  = $urandom_range(10, 150);
      repeat (seg) begin
        @(posedge clk_i);
        if (hold_req) begin
          m_tready <= 1'b0;
          repeat (HOLD_CYCLES) @(posedge clk_i);
          hold_req = 1'b0;
        end
        phase++;
        case (mode)
          0: m_tready <= 1'b1;
          1: m_tready <= 1'($urandom_range(0, 1));
          2: m_tready <= ($urandom_range(0, 3) == 0);
          default: m_tready <= (phase % 3 != 0);
        endcase
      end
    end
  end

  // offer one cell and hold it until the transaction completes
  task automatic drive_cell(logic [9:0] x, logic [9:0] y);
    s_tvalid <= 1'b1;
    s_tdata  <= {4'b0, y, x};
    @(posedge clk_i);
    while (!s_tready) @(posedge clk_i);
    sb.note_cell(x, y);
  endtask

  task automatic stop_sending();
    if (s_tvalid) s_tvalid <= 1'b0;
  endtask

  // drain and let the pipe empty before touching registers
  task automatic wait_idle();
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (LATENCY + 2) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [15:0] val);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk_i);
    sb.set_reg(idx, val);
  endtask

  task automatic load_regs(logic [15:0] oc, logic [15:0] orow,
                           logic [15:0] is, logic [15:0] ih);
    write_reg(CFG_ORIGIN_COL, oc);
    write_reg(CFG_ORIGIN_ROW, orow);
    write_reg(CFG_INV_SIDE, is);
    write_reg(CFG_INV_HEIGHT, ih);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [15:0] pick_origin();
    case ($urandom_range(0, 4))
      0: return 16'd0;
      1: return 16'hFFFF;
      2: return 16'd1023;
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic logic [15:0] pick_inv();
    case ($urandom_range(0, 5))
      0: return 16'd0;
      1: return 16'hFFFF;
      2: return 16'($urandom_range(0, 65535));
      default: return 16'($urandom_range(1024, 12000));
    endcase
  endfunction

  function automatic logic [9:0] pick_coord();
    if ($urandom_range(0, 9) == 0) return $urandom_range(0, 1) ? 10'd1023 : 10'd0;
    return 10'($urandom_range(0, 1023));
  endfunction

  task automatic run_random(int n, bit with_hold);
    int burst_left;
    int no_gap;
    burst_left = $urandom_range(1, 30);
    no_gap     = 0;
    for (int i = 0; i < n; i++) begin
      if (with_hold && i == n / 2) begin
        hold_req = 1'b1;
        no_gap   = 40;
      end
      drive_cell(pick_coord(), pick_coord());
      if (no_gap > 0) begin
        no_gap--;
      end else if (--burst_left == 0) begin
        s_tvalid <= 1'b0;
        repeat ($urandom_range(0, 7) == 0 ? $urandom_range(20, 60)
                                          : $urandom_range(1, 8)) @(posedge clk_i);
        burst_left = $urandom_range(1, 30);
      end
    end
    stop_sending();
  endtask

  initial begin : stimulus
    sb = new();
    rst_ni    <= 1'b0;
    cfg_we    <= 1'b0;
    cfg_addr  <= CFG_ORIGIN_COL;
    cfg_wdata <= '0;
    s_tvalid  <= 1'b0;
    s_tdata   <= '0;
    hold_req  = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // reset register values
    drive_cell(10'd0, 10'd0);
    drive_cell(10'd1023, 10'd1023);
    drive_cell(10'd0, 10'd1023);
    drive_cell(10'd1023, 10'd0);
    drive_cell(10'd5, 10'd7);
    drive_cell(10'd512, 10'd300);
    stop_sending();
    wait_idle();

    // far origin, largest reciprocals: negative saturation
    load_regs(16'd1023, 16'd1023, 16'hFFFF, 16'hFFFF);
    drive_cell(10'd0, 10'd0);
    drive_cell(10'd1023, 10'd1023);
    drive_cell(10'd0, 10'd1023);
    drive_cell(10'd1023, 10'd0);
    drive_cell(10'd1, 10'd1);
    stop_sending();
    wait_idle();

    // zero origin, largest reciprocals: positive saturation
    load_regs(16'd0, 16'd0, 16'hFFFF, 16'hFFFF);
    drive_cell(10'd1023, 10'd1023);
    drive_cell(10'd1023, 10'd0);
    drive_cell(10'd0, 10'd1023);
    drive_cell(10'd600, 10'd200);
    stop_sending();
    wait_idle();

    // zero reciprocals; origin writes carry high bits that must be dropped
    load_regs(16'hFE00, 16'hFDFF, 16'd0, 16'd0);
    drive_cell(10'd0, 10'd0);
    drive_cell(10'd1023, 10'd1023);
    drive_cell(10'd100, 10'd900);
    stop_sending();
    wait_idle();

    // one reciprocal zero, the other tiny
    load_regs(16'd300, 16'd700, 16'd1, 16'd0);
    drive_cell(10'd0, 10'd1023);
    drive_cell(10'd1023, 10'd0);
    drive_cell(10'd299, 10'd701);
    stop_sending();
    wait_idle();

    for (int ph = 0; ph < 8; ph++) begin
      load_regs(pick_origin(), pick_origin(), pick_inv(), pick_inv());
      run_random(125, ph == 3);
      wait_idle();
    end

    // back to the reset values for a final stretch
    load_regs(16'd0, 16'd0, 16'd4096, 16'd4730);
    run_random(60, 1'b0);

    while (sb.pending() != 0) @(posedge clk_i);
    repeat (LATENCY + 10) @(posedge clk_i);
    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

`default_nettype wire
